// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rtsp_mef_pkg.sv =====
// Package for the RTSP message end finder: payload types, character codes,
// header name table and register map. No dependencies.
`timescale 1ns / 1ps

package rtsp_mef_pkg;

    localparam int COUNT_BITS = 24;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int APB_ADDR_BITS = 3;
    localparam logic REG_MAX_BODY_LENGTH = 1'b0;
    localparam logic [COUNT_BITS-1:0] MAX_BODY_LENGTH_RESET = 24'd65535;

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int NAME_LEN = 14;
    localparam logic [3:0] NAME_LEN_CODE = 4'd14;
    localparam logic [7:0] HDR_NAME [0:NAME_LEN-1] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
        8'h2D, 8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
    };

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       buffer_last;
    } in_item_t;

    typedef struct packed {
        logic                  message_end;
        logic [COUNT_BITS-1:0] message_length;
        logic                  incomplete;
        logic                  length_error;
    } out_item_t;

endpackage

// ===== rtl/core/rtsp_message_end_finder.sv =====
// RTSP message end finder: one result per stream byte.
// Result path: the accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per clock while the result side is not stalled (result_ready low holds it).
// Reset (rst_n low, async): message state cleared, max_body_length = 65535.
// Depends on rtsp_mef_pkg.
`timescale 1ns / 1ps

module rtsp_message_end_finder (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    byte_valid,
    output logic                                    byte_ready,
    input  rtsp_mef_pkg::in_item_t                  byte_data,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output rtsp_mef_pkg::out_item_t                 result_data,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [rtsp_mef_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import rtsp_mef_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_SKIP,
        PH_DIGITS,
        PH_BODY
    } phase_t;

    localparam logic [1:0] CRLF_NONE   = 2'd0;
    localparam logic [1:0] CRLF_CR     = 2'd1;
    localparam logic [1:0] CRLF_CRLF   = 2'd2;
    localparam logic [1:0] CRLF_CRLFCR = 2'd3;

    logic [COUNT_BITS-1:0] max_len_reg;

    logic                  s1_valid_reg;
    in_item_t              s1_data_reg;
    logic                  res_valid_reg;
    out_item_t             res_data_reg;

    phase_t                phase_reg, phase_next;
    logic [3:0]            name_pos_reg, name_pos_next;
    logic [1:0]            crlf_reg, crlf_next;
    logic [COUNT_BITS-1:0] accum_reg, accum_next;
    logic [COUNT_BITS-1:0] remain_reg, remain_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  present_reg, present_next;

    logic                  out_free;
    logic                  advance;
    out_item_t             res_next;

    logic [7:0]            b;
    logic                  last;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [COUNT_BITS+3:0] accum_mul;
    logic [COUNT_BITS-1:0] eff_len;
    logic                  blank;
    logic                  msg_end;

    // APB register
    assign pready = 1'b1;
    assign prdata = {{(32-COUNT_BITS){1'b0}}, max_len_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_BODY_LENGTH_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[APB_ADDR_BITS-1] == REG_MAX_BODY_LENGTH))
        begin
            max_len_reg <= pwdata[COUNT_BITS-1:0];
        end
    end

    // handshake
    assign out_free     = !res_valid_reg || result_ready;
    assign advance      = s1_valid_reg && out_free;
    assign byte_ready   = !s1_valid_reg || out_free;
    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

    assign b         = s1_data_reg.stream_byte;
    assign last      = s1_data_reg.buffer_last;
    assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign digit     = 4'(b - CHAR_ZERO);
    assign accum_mul = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                       + {{COUNT_BITS{1'b0}}, digit};

    always_comb
    begin
        phase_next    = phase_reg;
        name_pos_next = name_pos_reg;
        crlf_next     = crlf_reg;
        accum_next    = accum_reg;
        remain_next   = remain_reg;
        present_next  = present_reg;
        blank         = 1'b0;
        msg_end       = 1'b0;
        eff_len       = '0;

        count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

        if (phase_reg == PH_BODY)
        begin
            if (remain_reg != '0)
            begin
                remain_next = remain_reg - 1'b1;
            end
            msg_end = (remain_next == '0);
        end
        else
        begin
            // blank line tracking
            if (b == CHAR_CR)
            begin
                crlf_next = (crlf_reg == CRLF_CRLF) ? CRLF_CRLFCR : CRLF_CR;
            end
            else if (b == CHAR_LF)
            begin
                if (crlf_reg == CRLF_CRLFCR)
                begin
                    crlf_next = CRLF_NONE;
                    blank     = 1'b1;
                end
                else
                begin
                    crlf_next = (crlf_reg == CRLF_CR) ? CRLF_CRLF : CRLF_NONE;
                end
            end
            else
            begin
                crlf_next = CRLF_NONE;
            end

            case (phase_reg)
                PH_HDR:
                begin
                    if (!present_reg)
                    begin
                        if (b == HDR_NAME[name_pos_reg])
                        begin
                            name_pos_next = name_pos_reg + 1'b1;
                        end
                        else
                        begin
                            name_pos_next = (b == HDR_NAME[0]) ? 4'd1 : 4'd0;
                        end
                        if (name_pos_next == NAME_LEN_CODE)
                        begin
                            name_pos_next = '0;
                            phase_next    = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (is_digit)
                    begin
                        accum_next = {{(COUNT_BITS-4){1'b0}}, digit};
                        phase_next = PH_DIGITS;
                    end
                    else if (b != CHAR_COLON && b != CHAR_SPACE && b != CHAR_TAB)
                    begin
                        phase_next = PH_HDR;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        accum_next = (accum_mul[COUNT_BITS+3:COUNT_BITS] != '0)
                                     ? COUNT_MAX : accum_mul[COUNT_BITS-1:0];
                    end
                    else
                    begin
                        present_next = 1'b1;
                        phase_next   = PH_HDR;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR;
                end
            endcase

            if (blank)
            begin
                eff_len = (accum_next > max_len_reg) ? max_len_reg : accum_next;
                if (present_next && eff_len != '0)
                begin
                    phase_next  = PH_BODY;
                    remain_next = eff_len;
                end
                else
                begin
                    msg_end = 1'b1;
                end
            end
        end

        res_next.message_end    = msg_end;
        res_next.message_length = count_next;
        res_next.incomplete     = last && !msg_end;
        res_next.length_error   = (accum_next > max_len_reg) || (count_next == COUNT_MAX);

        if (msg_end || last)
        begin
            phase_next    = PH_HDR;
            name_pos_next = '0;
            crlf_next     = CRLF_NONE;
            accum_next    = '0;
            remain_next   = '0;
            count_next    = '0;
            present_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR;
            name_pos_reg  <= '0;
            crlf_reg      <= CRLF_NONE;
            accum_reg     <= '0;
            remain_reg    <= '0;
            count_reg     <= '0;
            present_reg   <= 1'b0;
        end
        else
        begin
            if (byte_ready)
            begin
                s1_valid_reg <= byte_valid;
            end
            if (out_free)
            begin
                res_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                phase_reg    <= phase_next;
                name_pos_reg <= name_pos_next;
                crlf_reg     <= crlf_next;
                accum_reg    <= accum_next;
                remain_reg   <= remain_next;
                count_reg    <= count_next;
                present_reg  <= present_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            s1_data_reg <= byte_data;
        end
        if (advance)
        begin
            res_data_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/rtsp_mef_checker.sv =====
// Port-level checker for the RTSP message end finder, bound to the top level.
// Depends on rtsp_mef_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtsp_mef_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     result_valid,
    input  logic                     result_ready,
    input  rtsp_mef_pkg::out_item_t  result_data
);
    import rtsp_mef_pkg::*;

    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_data), "stalled result changed")
    `ASSERT_IMPLY(a_end_xor_incomplete, clk, rst_n, result_valid, !(result_data.message_end && result_data.incomplete), "end and incomplete together")
    `ASSERT_IMPLY(a_length_nonzero, clk, rst_n, result_valid, result_data.message_length != '0, "zero message length")
    `ASSERT_IMPLY(a_saturation_flag, clk, rst_n, result_valid && (result_data.message_length == COUNT_MAX), result_data.length_error, "saturated count without error")

endmodule

bind rtsp_message_end_finder rtsp_mef_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

// ===== test/rtsp_message_end_finder_tb.sv =====
// Testbench for rtsp_message_end_finder: drives RTSP-style byte streams, predicts each
// per-byte result (end, length, incomplete, length error) and checks them in order.
// Depends on rtsp_mef_pkg and the rtsp_message_end_finder RTL.
`timescale 1ns / 1ps

module rtsp_message_end_finder_tb;
    import rtsp_mef_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [APB_ADDR_BITS-1:0] MAX_BODY_ADDR = APB_ADDR_BITS'(REG_MAX_BODY_LENGTH) << 2;

    typedef enum logic [1:0] {SCAN_NAME, SKIP_SEP, READ_VALUE, IN_BODY} hdr_phase_e;

    class msg_end_scoreboard;
        logic [COUNT_BITS-1:0] max_body;
        int unsigned           name_pos;
        hdr_phase_e            phase;
        logic [1:0]            crlf;
        logic [COUNT_BITS-1:0] value_acc;
        logic [COUNT_BITS-1:0] body_left;
        logic [COUNT_BITS-1:0] msg_bytes;
        bit                    have_length;
        out_item_t             pending[$];
        int                    errors;
        int                    requests;
        int                    ends;
        int                    incompletes;
        int                    len_errors;

        function new();
            max_body = MAX_BODY_LENGTH_RESET;
            errors = 0;
            requests = 0;
            ends = 0;
            incompletes = 0;
            len_errors = 0;
            clear_message();
        endfunction

        function void clear_message();
            name_pos = 0;
            phase = SCAN_NAME;
            crlf = 2'd0;
            value_acc = '0;
            body_left = '0;
            msg_bytes = '0;
            have_length = 1'b0;
        endfunction

        function void note_byte(in_item_t it);
            logic [7:0]            b;
            bit                    done;
            bit                    blank;
            bit                    is_digit;
            logic [31:0]           v;
            logic [COUNT_BITS-1:0] eff;
            int unsigned           p;
            out_item_t             want;
            b = it.stream_byte;
            done = 1'b0;
            blank = 1'b0;
            is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
            if (msg_bytes != COUNT_MAX)
                msg_bytes++;
            if (phase == IN_BODY)
            begin
                if (body_left != 0)
                    body_left--;
                if (body_left == 0)
                    done = 1'b1;
            end
            else
            begin
                // blank line: CR LF CR LF
                if (b == CHAR_CR)
                    crlf = (crlf == 2'd2) ? 2'd3 : 2'd1;
                else if (b == CHAR_LF)
                begin
                    if (crlf == 2'd3)
                    begin
                        crlf = 2'd0;
                        blank = 1'b1;
                    end
                    else
                        crlf = (crlf == 2'd1) ? 2'd2 : 2'd0;
                end
                else
                    crlf = 2'd0;
                case (phase)
                    SCAN_NAME:
                    begin
                        if (!have_length)
                        begin
                            p = name_pos % NAME_LEN;
                            if (b == HDR_NAME[p])
                                name_pos = p + 1;
                            else
                                name_pos = (b == HDR_NAME[0]) ? 1 : 0;
                            if (name_pos >= NAME_LEN)
                            begin
                                name_pos = 0;
                                phase = SKIP_SEP;
                            end
                        end
                    end
                    SKIP_SEP:
                    begin
                        if (is_digit)
                        begin
                            value_acc = COUNT_BITS'(b - CHAR_ZERO);
                            phase = READ_VALUE;
                        end
                        else if (b != CHAR_COLON && b != CHAR_SPACE && b != CHAR_TAB)
                            phase = SCAN_NAME;
                    end
                    READ_VALUE:
                    begin
                        if (is_digit)
                        begin
                            v = 32'(value_acc) * 32'd10 + 32'(b) - 32'(CHAR_ZERO);
                            value_acc = (v > 32'(COUNT_MAX)) ? COUNT_MAX : v[COUNT_BITS-1:0];
                        end
                        else
                        begin
                            have_length = 1'b1;
                            phase = SCAN_NAME;
                        end
                    end
                    default: ;
                endcase
                if (blank)
                begin
                    eff = (value_acc > max_body) ? max_body : value_acc;
                    if (have_length && eff != 0)
                    begin
                        phase = IN_BODY;
                        body_left = eff;
                    end
                    else
                        done = 1'b1;
                end
            end
            want.message_end = done;
            want.message_length = msg_bytes;
            want.incomplete = it.buffer_last && !done;
            want.length_error = (value_acc > max_body) || (msg_bytes == COUNT_MAX);
            pending.push_back(want);
            requests++;
            ends += done;
            incompletes += want.incomplete;
            len_errors += want.length_error;
            if (done || it.buffer_last)
                clear_message();
        endfunction

        function void flag(string field, logic [COUNT_BITS-1:0] want, logic [COUNT_BITS-1:0] got);
            errors++;
            if (errors <= 40)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result %h, expected none", $time, got);
                return;
            end
            want = pending.pop_front();
            if (got.message_end !== want.message_end)
                flag("message_end", want.message_end, got.message_end);
            if (got.message_length !== want.message_length)
                flag("message_length", want.message_length, got.message_length);
            if (got.incomplete !== want.incomplete)
                flag("incomplete", want.incomplete, got.incomplete);
            if (got.length_error !== want.length_error)
                flag("length_error", want.length_error, got.length_error);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     byte_valid = 1'b0;
    logic                     byte_ready;
    in_item_t                 byte_data = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    out_item_t                result_data;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    msg_end_scoreboard sb;
    in_item_t          stream_q[$];
    bit                calm = 1'b0;
    int                stall_left = 0;
    int unsigned       cycles = 0;

    rtsp_message_end_finder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rtsp_message_end_finder_tb NOT OK");
            $finish;
        end
    end

    // result side: accept, then choose next ready with stall bursts
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result_data);
        if (calm)
            result_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    function automatic void put_byte(logic [7:0] b, logic last);
        in_item_t it;
        it.stream_byte = b;
        it.buffer_last = last;
        stream_q.push_back(it);
    endfunction

    function automatic void put_text(string s);
        foreach (s[i])
            put_byte(s[i], 1'b0);
    endfunction

    function automatic void put_sep();
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 2))
                0: put_byte(CHAR_COLON, 1'b0);
                1: put_byte(CHAR_SPACE, 1'b0);
                default: put_byte(CHAR_TAB, 1'b0);
            endcase
        end
    endfunction

    function automatic void put_filler();
        case ($urandom_range(0, 5))
            0: put_text("CSeq: 3\r\n");
            1: put_text("Session: 7\r\n");
            2: put_text("CContent-Lengt\r\n");
            3: put_text("A\r\n\nB\r\n");
            4: put_text("X:\r\r\n");
            default: put_text("Range: npt=0-\r\n");
        endcase
    endfunction

    // writes a length header and returns the value it carries, saturated
    function automatic longint unsigned put_length(logic [COUNT_BITS-1:0] limit);
        string           d;
        int              r;
        longint unsigned v;
        r = $urandom_range(0, 99);
        d = "";
        if (r < 60)
            d = $sformatf("%0d", $urandom_range(0, 24));
        else if (r < 70)
            d = {"00", $sformatf("%0d", $urandom_range(0, 12))};
        else if (r < 80)
            d = $sformatf("%0d", longint'(limit) + $urandom_range(1, 3));
        else if (r < 90)
            repeat ($urandom_range(8, 12)) d = {d, "9"};
        else
            d = $sformatf("%0d", $urandom_range(0, 1000));
        put_text("Content-Length");
        put_sep();
        put_text({d, "\r\n"});
        v = 0;
        foreach (d[i])
        begin
            v = v * 10 + (d[i] - CHAR_ZERO);
            if (v > COUNT_MAX)
                v = COUNT_MAX;
        end
        return v;
    endfunction

    function automatic void add_message(logic [COUNT_BITS-1:0] limit);
        int              start;
        int              pick;
        int              cut;
        longint unsigned val;
        longint unsigned extra;
        longint unsigned eff;
        bit              has_len;
        start = stream_q.size();
        has_len = 1'b0;
        val = 0;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0)
            put_text("PLAY * RTSP/1.0\r\n");
        if ($urandom_range(0, 1) == 0)
            put_filler();
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)), 1'b0);
            put_text("\r\n");
        end
        else if (pick < 22)
        begin
            put_text("Content-Length");
            put_sep();
            put_text("n/a\r\n");
        end
        else if (pick < 85)
        begin
            val = put_length(limit);
            has_len = 1'b1;
        end
        // a later length header counts only when the first had no digits
        if (pick >= 10 && pick < 85 && $urandom_range(0, 3) == 0)
        begin
            extra = put_length(limit);
            if (!has_len)
            begin
                val = extra;
                has_len = 1'b1;
            end
        end
        if ($urandom_range(0, 1) == 0)
            put_filler();
        if (stream_q.size() == start)
            put_text("\r\n");
        put_text("\r\n");
        eff = has_len ? ((val > limit) ? limit : val) : 0;
        if (eff > 48)
        begin
            repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)), 1'b0);
            put_byte(8'($urandom_range(0, 255)), 1'b1);
        end
        else
        begin
            repeat (int'(eff)) put_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 19) == 0)
                stream_q[stream_q.size()-1].buffer_last = 1'b1;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            cut = $urandom_range(start, stream_q.size() - 1);
            stream_q[cut].buffer_last = 1'b1;
            while (stream_q.size() > cut + 1)
                void'(stream_q.pop_back());
        end
    endfunction

    function automatic void fill_stream(logic [COUNT_BITS-1:0] limit, int count);
        int target;
        target = stream_q.size() + count;
        while (stream_q.size() < target)
            add_message(limit);
        put_byte(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    task automatic send_request(in_item_t it);
        byte_valid <= 1'b1;
        byte_data <= it;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        sb.note_byte(it);
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0)
        begin
            send_request(stream_q.pop_front());
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                byte_valid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
        end
        byte_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(logic [COUNT_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= MAX_BODY_ADDR;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.max_body = value;
    endtask

    task automatic read_limit(logic [COUNT_BITS-1:0] want);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= MAX_BODY_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(want))
        begin
            sb.errors++;
            $display("%0t: max_body_length read expected %0d, got %0d", $time, want, got);
        end
    endtask

    initial
    begin
        logic [COUNT_BITS-1:0] limits [5];
        sb = new();
        limits[0] = '0;
        limits[1] = COUNT_MAX;
        limits[2] = 24'd5;
        limits[3] = 24'($urandom_range(1, 300));
        limits[4] = MAX_BODY_LENGTH_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_limit(MAX_BODY_LENGTH_RESET);
        // blank line alone, extreme bytes cut short, end together with buffer last
        put_text("\r\n\r\n");
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_text("Content-Length:1\r\n\r\n");
        put_byte(8'h5A, 1'b1);
        fill_stream(MAX_BODY_LENGTH_RESET, 100);
        send_stream();
        foreach (limits[i])
        begin
            wait_drained();
            if (i == 4)
                calm = 1'b1;
            write_limit(limits[i]);
            read_limit(limits[i]);
            fill_stream(limits[i], 100);
            send_stream();
        end
        wait_drained();
        repeat (8) @(posedge clk);
        $display("%0d bytes over 6 length limits (0 to max): %0d message ends, %0d cut short,",
                 sb.requests, sb.ends, sb.incompletes);
        $display("%0d bytes flagged with a length error, %0d mismatches", sb.len_errors, sb.errors);
        if (sb.errors == 0)
            $display("rtsp_message_end_finder_tb OK");
        else
            $display("rtsp_message_end_finder_tb NOT OK");
        $finish;
    end

endmodule
